// ===== hw/rtl/bpa_pkg.sv =====
package bpa_pkg;

  localparam int unsigned PixelW     = 8;
  localparam int unsigned DimW       = 14;
  localparam int unsigned TextRowW   = 13;
  localparam int unsigned CharW      = 7;
  localparam int unsigned CfgIndexW  = 2;

  // Register indexes of the configuration port.
  localparam logic [CfgIndexW-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Byte position within a pixel.
  localparam logic [1:0] PHASE_BLUE  = 2'd0;
  localparam logic [1:0] PHASE_GREEN = 2'd1;
  localparam logic [1:0] PHASE_RED   = 2'd2;

  // Q16 luminance weights; they sum to 65536.
  localparam logic [15:0] COEF_R = 16'd13933;
  localparam logic [15:0] COEF_G = 16'd46871;
  localparam logic [15:0] COEF_B = 16'd4732;

  // Text rows are floor(height * 9 / 19); the division by 19 is a
  // multiplication by ceil(2^22 / 19), exact for every product below 2^18.
  localparam logic [17:0] ASPECT_NUM  = 18'd9;
  localparam logic [17:0] RECIP_19    = 18'd220753;
  localparam int unsigned RECIP_SHIFT = 22;

  // Selected scanlines advance by 19/9: two whole rows plus one ninth.
  localparam logic [3:0] FRAC_LAST = 4'd8;

  typedef logic [CharW-1:0] char_t;

  // Shade ramp, dark to light.
  localparam char_t SHADE_RAMP [7] = '{
    7'h23, 7'h4f, 7'h6f, 7'h3a, 7'h2a, 7'h2e, 7'h20
  };

  // Smallest luminance at which floor(lum * 6 / 255) reaches 1 .. 6.
  localparam logic [7:0] LEVEL_STEP [6] = '{
    8'd43, 8'd85, 8'd128, 8'd170, 8'd213, 8'd255
  };

  function automatic char_t shade_of(input logic [7:0] lum);
    logic [2:0] level;
    level = 3'd0;
    for (int k = 0; k < 6; k++) begin
      if (lum >= LEVEL_STEP[k]) begin
        level = 3'(k + 1);
      end
    end
    return SHADE_RAMP[3'd6 - level];
  endfunction

endpackage

// ===== hw/rtl/bpa_if.sv =====
interface bpa_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [bpa_pkg::PixelW-1:0]    pixel_byte;

  modport source (output valid, output pixel_byte, input ready);
  modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface bpa_shade_if;
  logic                          valid;
  logic                          ready;
  logic [bpa_pkg::CharW-1:0]     shade_char;
  logic [7:0]                    luminance;
  logic [bpa_pkg::TextRowW-1:0]  text_row;
  logic [bpa_pkg::DimW-1:0]      text_column;
  logic                          row_last;
  logic                          frame_last;

  modport source (output valid, output shade_char, output luminance, output text_row,
                  output text_column, output row_last, output frame_last, input ready);
  modport sink   (input valid, input shade_char, input luminance, input text_row,
                  input text_column, input row_last, input frame_last, output ready);
endinterface

// ===== hw/rtl/bpa_shade.sv =====
module bpa_shade (
  input  logic [7:0]                 red_i,
  input  logic [7:0]                 green_i,
  input  logic [7:0]                 blue_i,
  output logic [7:0]                 luminance_o,
  output logic [bpa_pkg::CharW-1:0]  shade_char_o
);

  logic [23:0] weighted_sum;

  // The weights sum to 2^16, so the sum never exceeds 24 bits.
  assign weighted_sum = 24'(bpa_pkg::COEF_R) * 24'(red_i)
                      + 24'(bpa_pkg::COEF_G) * 24'(green_i)
                      + 24'(bpa_pkg::COEF_B) * 24'(blue_i);

  assign luminance_o  = weighted_sum[23:16];
  assign shade_char_o = bpa_pkg::shade_of(weighted_sum[23:16]);

endmodule

// ===== hw/rtl/bmp_pixel_to_ascii_shade_unit.sv =====
// Converts the pixel array of a 24-bit bitmap, one byte per transfer in storage order
// (blue, green, red, then padding to a 4-byte boundary at the end of each scanline),
// into shade characters. Only scanlines floor(y*19/9) are kept, giving floor(H*9/19)
// text rows; each kept pixel yields one character with its luminance, text row, column
// and end-of-row and end-of-frame flags. One byte is taken every cycle while results
// are being drained; a result passes from the red byte of its pixel through a pixel
// register and then the output register. Any write to the width or height
// register returns the stream to the start of a frame.
module bmp_pixel_to_ascii_shade_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bpa_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [bpa_pkg::DimW-1:0]        cfg_wdata_i,
  bpa_pixel_if.sink                       pixel_in,
  bpa_shade_if.source                     shade_out
);

  localparam int unsigned DimW  = bpa_pkg::DimW;
  localparam int unsigned TrowW = bpa_pkg::TextRowW;

  // Configuration, held in effective form (zero acts as one).
  logic [DimW-1:0]  width_q;
  logic [DimW-1:0]  height_q;
  logic [TrowW-1:0] text_rows_q;
  logic [DimW-1:0]  cfg_eff;
  logic [35:0]      text_rows_prod;

  // Stream position.
  logic [1:0]       phase_q, phase_d;
  logic [15:0]      held_bg_q, held_bg_d;
  logic [DimW-1:0]  col_q, col_d;
  logic [1:0]       pad_q, pad_d;
  logic [DimW-1:0]  src_q, src_d;
  logic [TrowW-1:0] trc_q, trc_d;
  logic [DimW-1:0]  nsr_q, nsr_d;
  logic [3:0]       frac_q, frac_d;

  // Pixel register and output register.
  logic             a_valid_q;
  logic [7:0]       a_red_q, a_green_q, a_blue_q;
  logic [TrowW-1:0] a_row_q;
  logic [DimW-1:0]  a_col_q;
  logic             a_row_last_q, a_frame_last_q;
  logic             b_valid_q;

  logic             in_fire, b_free, a_move, pixel_done, selected, row_end, frame_end;
  logic [DimW:0]    col_inc, src_inc;
  logic [7:0]       lum_c;
  logic [bpa_pkg::CharW-1:0] char_c;

  assign cfg_eff        = (cfg_wdata_i == '0) ? DimW'(1) : cfg_wdata_i;
  assign text_rows_prod = 36'({4'd0, cfg_eff} * bpa_pkg::ASPECT_NUM) * 36'(bpa_pkg::RECIP_19);

  assign b_free          = !b_valid_q || shade_out.ready;
  assign a_move          = a_valid_q && b_free;
  assign pixel_in.ready  = !a_valid_q || b_free;
  assign in_fire         = pixel_in.valid && pixel_in.ready;

  assign col_inc    = {1'b0, col_q} + (DimW+1)'(1);
  assign src_inc    = {1'b0, src_q} + (DimW+1)'(1);
  assign row_end    = col_inc >= {1'b0, width_q};
  assign selected   = (trc_q < text_rows_q) && (src_q == nsr_q);
  assign frame_end  = row_end && (({1'b0, trc_q} + (TrowW+1)'(1)) == {1'b0, text_rows_q});
  assign pixel_done = in_fire && (pad_q == 2'd0) && (phase_q == bpa_pkg::PHASE_RED);

  always_comb begin
    phase_d   = phase_q;
    held_bg_d = held_bg_q;
    col_d     = col_q;
    pad_d     = pad_q;
    src_d     = src_q;
    trc_d     = trc_q;
    nsr_d     = nsr_q;
    frac_d    = frac_q;
    if (in_fire) begin
      if (pad_q != 2'd0) begin
        pad_d = pad_q - 2'd1;
      end else if (phase_q == bpa_pkg::PHASE_GREEN) begin
        held_bg_d = {pixel_in.pixel_byte, held_bg_q[7:0]};
        phase_d   = bpa_pkg::PHASE_RED;
      end else if (phase_q != bpa_pkg::PHASE_RED) begin
        held_bg_d = {8'd0, pixel_in.pixel_byte};
        phase_d   = bpa_pkg::PHASE_GREEN;
      end else begin
        phase_d = bpa_pkg::PHASE_BLUE;
        if (!row_end) begin
          col_d = col_inc[DimW-1:0];
        end else begin
          col_d = '0;
          pad_d = width_q[1:0];
          if (selected) begin
            trc_d = trc_q + TrowW'(1);
            if (frac_q == bpa_pkg::FRAC_LAST) begin
              frac_d = '0;
              nsr_d  = nsr_q + DimW'(3);
            end else begin
              frac_d = frac_q + 4'd1;
              nsr_d  = nsr_q + DimW'(2);
            end
          end
          if (src_inc >= {1'b0, height_q}) begin
            src_d  = '0;
            trc_d  = '0;
            nsr_d  = '0;
            frac_d = '0;
          end else begin
            src_d = src_inc[DimW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= DimW'(1);
      height_q    <= DimW'(1);
      text_rows_q <= '0;
      phase_q     <= bpa_pkg::PHASE_BLUE;
      held_bg_q   <= '0;
      col_q       <= '0;
      pad_q       <= '0;
      src_q       <= '0;
      trc_q       <= '0;
      nsr_q       <= '0;
      frac_q      <= '0;
    end else if (cfg_we_i && (cfg_index_i == bpa_pkg::REG_IMAGE_WIDTH ||
                              cfg_index_i == bpa_pkg::REG_IMAGE_HEIGHT)) begin
      if (cfg_index_i == bpa_pkg::REG_IMAGE_WIDTH) begin
        width_q <= cfg_eff;
      end else begin
        height_q    <= cfg_eff;
        text_rows_q <= text_rows_prod[bpa_pkg::RECIP_SHIFT+TrowW-1:bpa_pkg::RECIP_SHIFT];
      end
      phase_q   <= bpa_pkg::PHASE_BLUE;
      held_bg_q <= '0;
      col_q     <= '0;
      pad_q     <= '0;
      src_q     <= '0;
      trc_q     <= '0;
      nsr_q     <= '0;
      frac_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      held_bg_q <= held_bg_d;
      col_q     <= col_d;
      pad_q     <= pad_d;
      src_q     <= src_d;
      trc_q     <= trc_d;
      nsr_q     <= nsr_d;
      frac_q    <= frac_d;
    end
  end

  // The pixel register holds a kept pixel until the output register is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (pixel_done && selected) begin
      a_valid_q <= 1'b1;
    end else if (a_move) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pixel_done && selected) begin
      a_red_q        <= pixel_in.pixel_byte;
      a_green_q      <= held_bg_q[15:8];
      a_blue_q       <= held_bg_q[7:0];
      a_row_q        <= trc_q;
      a_col_q        <= col_q;
      a_row_last_q   <= row_end;
      a_frame_last_q <= frame_end;
    end
  end

  bpa_shade u_shade (
    .red_i        (a_red_q),
    .green_i      (a_green_q),
    .blue_i       (a_blue_q),
    .luminance_o  (lum_c),
    .shade_char_o (char_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_free) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      shade_out.shade_char  <= char_c;
      shade_out.luminance   <= lum_c;
      shade_out.text_row    <= a_row_q;
      shade_out.text_column <= a_col_q;
      shade_out.row_last    <= a_row_last_q;
      shade_out.frame_last  <= a_frame_last_q;
    end
  end

  assign shade_out.valid = b_valid_q;

`ifndef NO_ASSERTIONS
  a_frame_implies_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shade_out.valid |-> (!shade_out.frame_last || shade_out.row_last))
    else $error("frame end flagged on a character that does not end its row");

  a_pixel_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !b_free && !cfg_we_i) |=> (a_valid_q && $stable(a_col_q) && $stable(a_row_q)))
    else $error("pending pixel lost while the output was stalled");

  a_pad_at_pixel_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pad_q != 2'd0) |-> (phase_q == bpa_pkg::PHASE_BLUE))
    else $error("padding pending in the middle of a pixel");

  a_column_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < width_q)
    else $error("column count reached the image width");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (src_q < height_q) && (trc_q <= text_rows_q))
    else $error("scanline or text row count out of range");
`endif

endmodule
